FILE: design/mf3_pkg.sv
// shared types, constants and compare helpers for the 3x3 median filter
package mf3_pkg;

	localparam int PIX_W      = 8;
	localparam int POS_W      = 10;
	localparam int DIM_W      = 11;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MIN_SIZE   = 3;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int WIN_N      = 9;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [DIM_W-1:0] dim_t;

	localparam dim_t DIM_MIN   = dim_t'(MIN_SIZE);
	localparam dim_t DIM_MAX_W = dim_t'(MAX_WIDTH);
	localparam dim_t DIM_MAX_H = dim_t'(MAX_HEIGHT);

	// configuration register indexes
	localparam logic [0:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;

	// one full neighbourhood plus the position of its centre
	typedef struct packed {
		pix_t [WIN_N-1:0] px;
		pos_t             row;
		pos_t             col;
		logic             done;
	} win_t;

	// three sorted triples
	typedef struct packed {
		pix_t [WIN_N-1:0] px;
		pos_t             row;
		pos_t             col;
		logic             done;
	} tri_t;

	// three median candidates
	typedef struct packed {
		pix_t [2:0] px;
		pos_t       row;
		pos_t       col;
		logic       done;
	} cand_t;

	function automatic pix_t min2(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(pix_t a, pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
		return min2(min2(a, b), c);
	endfunction

	function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
		return max2(max2(a, b), c);
	endfunction

	function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

endpackage

FILE: design/mf3_window.sv
// position counters, line stores and window columns (first pipeline stage)
module mf3_window
	import mf3_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_idx,
	input  dim_t       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  pix_t       pixel,
	input  logic       frame_start,
	output logic       win_valid,
	input  logic       win_stall,
	output win_t       win
);

	dim_t width_q, height_q;
	pos_t row_q, col_q;

	logic accept, adv1;
	dim_t c_base, r_base, c_nxt, r_nxt;
	pos_t c_in, r_in, col_d, row_d;

	logic v_s1, emit_s1, done_s1, fwd_s1;
	pix_t px_s1;
	pos_t r_s1, c_s1;

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q, fwd_q;
	pix_t up, mid;
	pix_t win_q [6];

	function automatic dim_t clamp_dim(dim_t v, dim_t hi);
		if (v < DIM_MIN) begin
			return DIM_MIN;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_MAX_W;
			height_q <= DIM_MAX_H;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_data, DIM_MAX_W);
				CFG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_data, DIM_MAX_H);
			endcase
		end
	end

	// position of the arriving pixel and the counters after it
	always_comb begin
		c_base = frame_start ? '0 : {1'b0, col_q};
		r_base = frame_start ? '0 : {1'b0, row_q};
		if (c_base >= width_q) begin
			c_base = '0;
			r_base = r_base + dim_t'(1);
		end
		if (r_base >= height_q) begin
			r_base = '0;
		end
		c_in  = c_base[POS_W-1:0];
		r_in  = r_base[POS_W-1:0];
		c_nxt = {1'b0, c_in} + dim_t'(1);
		r_nxt = {1'b0, r_in} + dim_t'(1);
		if (c_nxt >= width_q) begin
			col_d = '0;
			row_d = (r_nxt >= height_q) ? '0 : r_nxt[POS_W-1:0];
		end else begin
			col_d = c_nxt[POS_W-1:0];
			row_d = r_in;
		end
	end

	assign adv1      = v_s1 && (!emit_s1 || !win_stall);
	assign in_stall  = v_s1 && !adv1;
	assign accept    = in_valid && !in_stall;
	assign win_valid = v_s1 && emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept) begin
				row_q <= row_d;
				col_q <= col_d;
				v_s1  <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			r_s1    <= r_in;
			c_s1    <= c_in;
			emit_s1 <= (r_in >= pos_t'(2)) && (c_in >= pos_t'(2));
			done_s1 <= ({1'b0, r_in} == height_q - dim_t'(1)) &&
			           ({1'b0, c_in} == width_q - dim_t'(1));
		end
	end

	// both line stores share one entry per column: {upper, middle}
	always_ff @(posedge clk) begin
		if (adv1) begin
			mem[c_s1[ADDR_W-1:0]] <= {mid, px_s1};
		end
		if (accept) begin
			rd_q   <= mem[c_in[ADDR_W-1:0]];
			fwd_q  <= {mid, px_s1};
			fwd_s1 <= v_s1 && (c_s1 == c_in);
		end
	end

	// the item just ahead wrote the same column on the edge this one read it
	assign {up, mid} = fwd_s1 ? fwd_q : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up;
			win_q[4] <= mid;
			win_q[5] <= px_s1;
		end
	end

	always_comb begin
		win.px[0] = win_q[0];
		win.px[1] = win_q[3];
		win.px[2] = up;
		win.px[3] = win_q[1];
		win.px[4] = win_q[4];
		win.px[5] = mid;
		win.px[6] = win_q[2];
		win.px[7] = win_q[5];
		win.px[8] = px_s1;
		win.row   = r_s1 - pos_t'(1);
		win.col   = c_s1 - pos_t'(1);
		win.done  = done_s1;
	end

endmodule

FILE: design/mf3_median.sv
// four-stage median of nine: row sort, candidate pick, final median of three
module mf3_median
	import mf3_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  win_valid,
	output logic  win_stall,
	input  win_t  win,
	output logic  res_valid,
	input  logic  res_stall,
	output pix_t  res_median,
	output pos_t  res_row,
	output pos_t  res_col,
	output logic  res_done
);

	logic  v_s2, v_s3, v_s4, v_s5;
	logic  rdy2, rdy3, rdy4, rdy5;
	win_t  win_s2;
	tri_t  tri_s3;
	cand_t cand_s4;
	pix_t  med_s5;
	pos_t  row_s5, col_s5;
	logic  done_s5;
	tri_t  tri_d;
	cand_t cand_d;

	assign rdy5      = !v_s5 || !res_stall;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign win_stall = !rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy2) v_s2 <= win_valid;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// sort each triple: lowest, middle, highest
	always_comb begin
		for (int t = 0; t < 3; t++) begin
			tri_d.px[3*t]   = min3(win_s2.px[3*t], win_s2.px[3*t+1], win_s2.px[3*t+2]);
			tri_d.px[3*t+1] = med3(win_s2.px[3*t], win_s2.px[3*t+1], win_s2.px[3*t+2]);
			tri_d.px[3*t+2] = max3(win_s2.px[3*t], win_s2.px[3*t+1], win_s2.px[3*t+2]);
		end
		tri_d.row  = win_s2.row;
		tri_d.col  = win_s2.col;
		tri_d.done = win_s2.done;
	end

	// largest low, middle of middles, smallest high
	always_comb begin
		cand_d.px[0] = max3(tri_s3.px[0], tri_s3.px[3], tri_s3.px[6]);
		cand_d.px[1] = med3(tri_s3.px[1], tri_s3.px[4], tri_s3.px[7]);
		cand_d.px[2] = min3(tri_s3.px[2], tri_s3.px[5], tri_s3.px[8]);
		cand_d.row   = tri_s3.row;
		cand_d.col   = tri_s3.col;
		cand_d.done  = tri_s3.done;
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			win_s2 <= win;
		end
		if (rdy3) begin
			tri_s3 <= tri_d;
		end
		if (rdy4) begin
			cand_s4 <= cand_d;
		end
		if (rdy5) begin
			med_s5  <= med3(cand_s4.px[0], cand_s4.px[1], cand_s4.px[2]);
			row_s5  <= cand_s4.row;
			col_s5  <= cand_s4.col;
			done_s5 <= cand_s4.done;
		end
	end

	assign res_valid  = v_s5;
	assign res_median = med_s5;
	assign res_row    = row_s5;
	assign res_col    = col_s5;
	assign res_done   = done_s5;

endmodule

FILE: design/median_filter_3x3_top.sv
// 3x3 median filter over a raster-order grey pixel stream
//
// Pixels come in raster order on in_valid/in_stall, one per unstalled clock;
// frame_start marks the first pixel of a frame. After the last pixel of a
// frame the position wraps to the top left on its own. For each pixel whose
// centre is off the one-pixel border, one item leaves on out_valid/out_stall
// with the median of the 3x3 neighbourhood, the centre's row and column, and
// frame_done on the last interior centre. Border pixels give no item.
// Throughput is one pixel per clock when the output is not stalled, set by
// one line store read at accept and one write as the item leaves the first
// of the five register stages (position/line store, window, row sort,
// candidate pick, final median). image_width and image_height are written
// on cfg_we with cfg_idx 0 and 1; the user must write them only while idle,
// as the block does not enforce it. Values are clamped to 3..1024.
// Reset clears the counters, window columns and valid bits and sets both
// sizes to 1024; line store contents are undefined until written.
// A stalled output holds its item; bubbles close up ahead of it, and
// in_stall rises only once every stage is full.
module median_filter_3x3_top
	import mf3_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_idx,
	input  dim_t       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  pix_t       pixel,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_stall,
	output pix_t       median_value,
	output pos_t       center_row,
	output pos_t       center_col,
	output logic       frame_done
);

	logic win_valid, win_stall;
	win_t win;

	mf3_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel       (pixel),
		.frame_start (frame_start),
		.win_valid   (win_valid),
		.win_stall   (win_stall),
		.win         (win)
	);

	mf3_median u_median (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (win_valid),
		.win_stall  (win_stall),
		.win        (win),
		.res_valid  (out_valid),
		.res_stall  (out_stall),
		.res_median (median_value),
		.res_row    (center_row),
		.res_col    (center_col),
		.res_done   (frame_done)
	);

endmodule
